// File: src/htfl_pkg.sv
// ----------------------------------------------------------------------------
// htfl_pkg: shared types and codes for the handle table allocator
// Action and status codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package htfl_pkg;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_FREE  = 2'd1;
   localparam logic [1:0] ACT_GET   = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_OWNER = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_REJECT    = 3'd3;
   localparam logic [2:0] ST_UNALLOC   = 3'd4;

   localparam logic [1:0] REG_MAX       = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_SPILL     = 2'd2;

   localparam int CFG_WIDTH = 13;
   localparam logic [15:0] FREE_OWNER = 16'hFFFF;

   typedef logic [CFG_WIDTH-1:0] cfg_type;

   typedef struct packed {
      cfg_type max_handles;
      cfg_type spill_threshold;
      cfg_type spill_count;
   } cfg_regs_type;

endpackage

// File: src/htfl_csr.sv
// ----------------------------------------------------------------------------
// htfl_csr: configuration registers
// APB-style write/read of the three allocator settings.
// ----------------------------------------------------------------------------
module htfl_csr import htfl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready,
   output cfg_regs_type cfg
);
   cfg_regs_type cfg_ff;
   logic         wr_en;
   logic [1:0]   idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_handles     <= cfg_type'(4096);
         cfg_ff.spill_threshold <= cfg_type'(100);
         cfg_ff.spill_count     <= cfg_type'(90);
      end else if (wr_en && csr_paddr[1:0] == 2'd0) begin
         case (idx)
            REG_MAX:       cfg_ff.max_handles     <= csr_pwdata[CFG_WIDTH-1:0];
            REG_THRESHOLD: cfg_ff.spill_threshold <= csr_pwdata[CFG_WIDTH-1:0];
            REG_SPILL:     cfg_ff.spill_count     <= csr_pwdata[CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (idx)
         REG_MAX:       csr_prdata = 32'(cfg_ff.max_handles);
         REG_THRESHOLD: csr_prdata = 32'(cfg_ff.spill_threshold);
         REG_SPILL:     csr_prdata = 32'(cfg_ff.spill_count);
         default:       csr_prdata = '0;
      endcase
   end
endmodule

// File: src/handle_table_free_list_allocator.sv
// ----------------------------------------------------------------------------
// handle_table_free_list_allocator
// Handle table with local/global free lists and a bump cursor, in one RAM.
// ----------------------------------------------------------------------------
//  channel  dir  ports        beat contents
//  req      in   req_t*       tdata: action[1:0] owner_id[17:2] handle_index[29:18]
//  rsp      out  rsp_t*       tdata: status, handle_out, entry_owner, entry_refcount
//  csr      in   csr_p*       max_handles @0, spill_threshold @4, spill_count @8
//
//  One request at a time. Free/get do one RAM read, then the result beat;
//  alloc first puts the chosen list head on the RAM address, then does one
//  registered RAM read, then the result beat (the write back lands during it).
//  A spill walks the link chain, one RAM read per link moved.
//  Reset is synchronous; the table RAM has no reset (entries beyond the
//  cursor are never used). rsp_tready low holds the beat in its register.
// ----------------------------------------------------------------------------
module handle_table_free_list_allocator import htfl_pkg::*; #(
   parameter int TABLE_DEPTH = 4096,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // action[1:0], owner_id[17:2], handle_index[29:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // status[2:0], handle_out[14:3], entry_owner[30:15],
                                    // entry_refcount[62:31]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int LW = AW + 1;              // link/cursor width, holds null
   localparam logic [LW-1:0] NULL_LINK = LW'(TABLE_DEPTH);
   localparam int EW = 16 + COUNT_WIDTH + LW;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RD    = 3'd1;  // RAM read data ready
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_WALK  = 3'd3;  // spill: link read data ready
   localparam logic [2:0] S_WSTEP = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   cfg_regs_type cfg;

   htfl_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   // entry: {owner, refcount, link}
   logic [EW-1:0] ram [TABLE_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) ram[wr_addr] <= wr_data;
      // a read of the entry being written sees the new data
      if (wr_en && wr_addr == rd_addr) rd_data_ff <= wr_data;
      else rd_data_ff <= ram[rd_addr];
   end

   logic [2:0]  state_ff, state_in;
   logic [1:0]  act_ff;
   logic [15:0] own_ff;
   logic [AW-1:0] h_ff;
   logic [LW-1:0] local_head_ff, global_head_ff, cursor_ff, local_count_ff;
   logic [LW-1:0] tail_ff, moved_ff;
   logic [2:0]  st_ff;
   logic [AW-1:0] hout_ff;
   logic [15:0] eown_ff;
   logic [COUNT_WIDTH-1:0] erc_ff;

   logic [15:0]            rd_own;
   logic [COUNT_WIDTH-1:0] rd_rc;
   logic [LW-1:0]          rd_link;
   assign {rd_own, rd_rc, rd_link} = rd_data_ff;

   logic [LW-1:0] limit, spill_n, cnt_inc;
   logic          h_valid;
   assign limit   = (32'(cfg.max_handles) < TABLE_DEPTH) ? LW'(cfg.max_handles) : NULL_LINK;
   assign spill_n = (cfg.spill_count == '0) ? LW'(1) : LW'(cfg.spill_count);
   assign h_valid = (LW'(h_ff) < cursor_ff) && (rd_own != FREE_OWNER);
   assign cnt_inc = local_count_ff + LW'(1);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = 64'({32'(erc_ff), eown_ff, 12'(hout_ff), st_ff});

   always_comb begin
      rd_addr = h_ff;
      if (state_ff == S_IDLE) rd_addr = req_tdata[18 +: AW];
      else if (state_ff == S_EXEC && act_ff == ACT_ALLOC) rd_addr = h_ff;
      else if (state_ff == S_WSTEP || state_ff == S_EXEC) rd_addr = tail_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      wr_en <= 1'b0;
      if (reset) begin
         state_ff       <= S_IDLE;
         local_head_ff  <= NULL_LINK;
         global_head_ff <= NULL_LINK;
         cursor_ff      <= '0;
         local_count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tdata[1:0] != 2'd3) begin
               act_ff   <= req_tdata[1:0];
               own_ff   <= req_tdata[17:2];
               h_ff     <= req_tdata[18 +: AW];
               state_ff <= S_RD;
               // for alloc, pick source now and read its link
               if (req_tdata[1:0] == ACT_ALLOC) begin
                  if (local_head_ff != NULL_LINK) h_ff <= local_head_ff[AW-1:0];
                  else if (global_head_ff != NULL_LINK) h_ff <= global_head_ff[AW-1:0];
                  state_ff <= S_EXEC;   // address settles next cycle
               end
            end
            S_EXEC: if (act_ff == ACT_ALLOC) state_ff <= S_RD;
                    else state_ff <= S_IDLE;
            S_RD: begin
               state_ff <= S_OUT;
               hout_ff <= h_ff; eown_ff <= '0; erc_ff <= '0; st_ff <= ST_OK;
               case (act_ff)
                  ACT_ALLOC: begin
                     wr_addr <= h_ff;
                     wr_data <= {own_ff, COUNT_WIDTH'(0), NULL_LINK};
                     if (own_ff == FREE_OWNER) begin
                        st_ff <= ST_BAD_OWNER; hout_ff <= '0;
                     end else if (local_head_ff != NULL_LINK) begin
                        local_head_ff  <= rd_link;
                        local_count_ff <= (local_count_ff != '0) ? local_count_ff - LW'(1) : '0;
                        wr_en <= 1'b1;
                     end else if (global_head_ff != NULL_LINK) begin
                        global_head_ff <= rd_link;
                        wr_en <= 1'b1;
                     end else if (cursor_ff < limit) begin
                        hout_ff <= cursor_ff[AW-1:0];
                        wr_addr <= cursor_ff[AW-1:0];
                        cursor_ff <= cursor_ff + LW'(1);
                        wr_en <= 1'b1;
                     end else begin
                        st_ff <= ST_FULL; hout_ff <= '0;
                     end
                  end
                  ACT_FREE: begin
                     if (!h_valid) st_ff <= ST_REJECT;
                     else begin
                        wr_en   <= 1'b1;
                        wr_addr <= h_ff;
                        wr_data <= {FREE_OWNER, rd_rc - COUNT_WIDTH'(1), local_head_ff};
                        local_head_ff  <= LW'(h_ff);
                        local_count_ff <= cnt_inc;
                        if (cnt_inc >= LW'(cfg.spill_threshold)) begin
                           tail_ff  <= LW'(h_ff);
                           moved_ff <= LW'(1);
                           state_ff <= S_WSTEP;
                        end
                     end
                  end
                  default: begin
                     if (!h_valid) st_ff <= ST_UNALLOC;
                     else begin
                        eown_ff <= rd_own; erc_ff <= rd_rc;
                     end
                  end
               endcase
            end
            // tail_ff is on the read address; its data is registered for S_WALK
            S_WSTEP: state_ff <= S_WALK;
            S_WALK: begin
               // the head entry write is forwarded into the walk's first read
               if (rd_link != NULL_LINK && moved_ff < spill_n) begin
                  tail_ff  <= rd_link;
                  moved_ff <= moved_ff + LW'(1);
                  state_ff <= S_WSTEP;
               end else begin
                  local_head_ff  <= rd_link;
                  local_count_ff <= (local_count_ff >= moved_ff) ?
                                    local_count_ff - moved_ff : '0;
                  wr_en   <= 1'b1;
                  wr_addr <= tail_ff[AW-1:0];
                  wr_data <= {rd_own, rd_rc, global_head_ff};
                  global_head_ff <= LW'(h_ff);
                  state_ff <= S_OUT;
               end
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
